// ===== rtl/core/ucm_pkg.sv =====
// ----------------------------------------------------------------------------
// ucm_pkg
// Shared widths, range constants and the case mapping functions for the
// Unicode case mapper.
// ----------------------------------------------------------------------------
package ucm_pkg;

   localparam int unsigned PointWidth = 21;
   localparam logic [PointWidth-1:0] MaxScalar = 21'h10FFFF;

   typedef logic [PointWidth-1:0] point_type;

   localparam point_type BlockOffset    = 21'h20;
   localparam point_type CyrillicOffset = 21'h50;
   localparam point_type CapYDiaeresis  = 21'h178;
   localparam point_type SmallYDiaeresis = 21'hFF;
   localparam point_type CapSharpS      = 21'h1E9E;
   localparam point_type SmallSharpS    = 21'hDF;
   localparam point_type FinalSigma     = 21'h3C2;
   localparam point_type CapSigma       = 21'h3A3;
   localparam point_type OneStep        = 21'h1;

   function automatic logic in_span(point_type v, point_type lo, point_type hi);
      in_span = (v >= lo) && (v <= hi);
   endfunction

   function automatic point_type map_lower(point_type v);
      point_type r;
      r = v;
      if (in_span(v, 21'h41, 21'h5A) || in_span(v, 21'hC0, 21'hD6) ||
          in_span(v, 21'hD8, 21'hDE) || in_span(v, 21'h391, 21'h3A1) ||
          in_span(v, 21'h3A3, 21'h3A9) || in_span(v, 21'h410, 21'h42F)) begin
         r = v + BlockOffset;
      end else if (in_span(v, 21'h400, 21'h40F)) begin
         r = v + CyrillicOffset;
      end else if (v == CapYDiaeresis) begin
         r = SmallYDiaeresis;
      end else if (v == CapSharpS) begin
         r = SmallSharpS;
      end else if (in_span(v, 21'h100, 21'h136) || in_span(v, 21'h14A, 21'h176) ||
                   in_span(v, 21'h460, 21'h480) || in_span(v, 21'h490, 21'h4BE) ||
                   in_span(v, 21'h4D0, 21'h52E)) begin
         r = v[0] ? v : v + OneStep;
      end else if (in_span(v, 21'h139, 21'h147) || in_span(v, 21'h179, 21'h17D) ||
                   in_span(v, 21'h4C1, 21'h4CB)) begin
         r = v[0] ? v + OneStep : v;
      end
      return r;
   endfunction

   function automatic point_type map_upper(point_type v);
      point_type r;
      r = v;
      if (in_span(v, 21'h61, 21'h7A) || in_span(v, 21'hE0, 21'hF6) ||
          in_span(v, 21'hF8, 21'hFE) || in_span(v, 21'h3B1, 21'h3C1) ||
          in_span(v, 21'h3C3, 21'h3C9) || in_span(v, 21'h430, 21'h44F)) begin
         r = v - BlockOffset;
      end else if (in_span(v, 21'h450, 21'h45F)) begin
         r = v - CyrillicOffset;
      end else if (v == SmallYDiaeresis) begin
         r = CapYDiaeresis;
      end else if (v == SmallSharpS) begin
         r = CapSharpS;
      end else if (v == FinalSigma) begin
         r = CapSigma;
      end else if (in_span(v, 21'h101, 21'h137) || in_span(v, 21'h14B, 21'h177) ||
                   in_span(v, 21'h461, 21'h481) || in_span(v, 21'h491, 21'h4BF) ||
                   in_span(v, 21'h4D1, 21'h52F)) begin
         r = v[0] ? v - OneStep : v;
      end else if (in_span(v, 21'h13A, 21'h148) || in_span(v, 21'h17A, 21'h17E) ||
                   in_span(v, 21'h4C2, 21'h4CC)) begin
         r = v[0] ? v : v - OneStep;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/unicode_case_mapper.sv =====
// ----------------------------------------------------------------------------
// unicode_case_mapper
// Simple case mapping of one code point to its lowercase and uppercase forms.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  req_      | in        | req_valid/req_ready  | req_code_point
//  rsp_      | out       | rsp_valid/rsp_ready  | rsp_lower_point, rsp_upper_point
//
//  Path: input register, then mapping logic into the result
//  register. One word per cycle sustained while rsp_ready is high.
//  Synchronous reset empties both stages; payload registers are not reset.
//  A stalled result holds its stage; the input stage still fills behind it.
// ----------------------------------------------------------------------------
module unicode_case_mapper
   import ucm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PointWidth-1:0] req_code_point,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PointWidth-1:0] rsp_lower_point,
   output logic [PointWidth-1:0] rsp_upper_point
);

   logic      in_valid_ff;
   logic      in_valid_in;
   point_type in_point_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   point_type lower_ff;
   point_type upper_ff;
   logic      out_take;
   logic      in_take;

   assign out_take  = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_take;
   assign in_take   = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (out_take) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_point_ff <= req_code_point;
      end
      if (out_take && in_valid_ff) begin
         lower_ff <= map_lower(in_point_ff);
         upper_ff <= map_upper(in_point_ff);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_lower_point = lower_ff;
   assign rsp_upper_point = upper_ff;

endmodule

// ===== rtl/core/ucm_checker.sv =====
// ----------------------------------------------------------------------------
// ucm_checker
// Port-level checks for the Unicode case mapper, bound to the top level.
// ----------------------------------------------------------------------------
module ucm_checker
   import ucm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [PointWidth-1:0] rsp_lower_point,
   input logic [PointWidth-1:0] rsp_upper_point
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lower_point)
                                  && $stable(rsp_upper_point))
      else $error("stalled result word changed");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while result stage empty");

   a_pass_through_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_upper_point > MaxScalar) |-> rsp_lower_point == rsp_upper_point)
      else $error("non-scalar value was mapped");

endmodule

bind unicode_case_mapper ucm_checker u_ucm_checker (.*);
